@@ rtl/packet_ack_range_tracker_top_assert.svh @@
// Assertion macros used by the tracker's top level.
`ifndef PACKET_ACK_RANGE_TRACKER_TOP_ASSERT_SVH
`define PACKET_ACK_RANGE_TRACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PART_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PART_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/part_pkg.sv @@
package part_pkg;

	localparam int DEF_FLIGHT_DEPTH  = 32;
	localparam int DEF_PENDING_DEPTH = 16;
	localparam int MAX_RESULTS       = 32;
	localparam int N_W               = $clog2(MAX_RESULTS + 1);
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	localparam logic [2:0] MODE_SEND  = 3'd0;
	localparam logic [2:0] MODE_RECV  = 3'd1;
	localparam logic [2:0] MODE_ACK   = 3'd2;
	localparam logic [2:0] MODE_SWEEP = 3'd3;
	localparam logic [2:0] MODE_TAKE  = 3'd4;

	localparam logic [2:0] EV_ASSIGNED  = 3'd0;
	localparam logic [2:0] EV_RX        = 3'd1;
	localparam logic [2:0] EV_DELIVERED = 3'd2;
	localparam logic [2:0] EV_FAILED    = 3'd3;
	localparam logic [2:0] EV_RANGE     = 3'd4;
	localparam logic [2:0] EV_NOTHING   = 3'd5;

	localparam logic [1:0] REG_SEND_ACKS    = 2'd0;
	localparam logic [1:0] REG_PROCESS_ACKS = 2'd1;
	localparam logic [1:0] REG_TIMEOUT      = 2'd2;

	typedef enum logic [2:0] {
		OP_SEND,
		OP_RECV,
		OP_ACK,
		OP_SWEEP,
		OP_TAKE,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] rx_sequence;
		logic [15:0] ack_start;
		logic [7:0]  ack_length;
		logic [31:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic        send_acks_enable;
		logic        process_acks_enable;
		logic [15:0] timeout_limit;
	} cfg_t;

endpackage

@@ rtl/packet_ack_range_tracker_top.sv @@
// Send, receive, take from an empty queue and unknown modes: result registered in the idle state.
// Send and receive items can be taken one per cycle, as the back end pops one every cycle.
// Take with a pending range: result from the take state. Ack and sweep walks: an eval state per
// step, with a fetch state after each retired in-flight entry for the registered read of the
// in-flight RAM; a skipped ack number stays in eval. A two-entry command queue lets start be
// taken during a walk. Results cannot be stalled. Reset clears control state and queues.
module packet_ack_range_tracker_top
	import part_pkg::*;
#(
	parameter int FLIGHT_DEPTH  = DEF_FLIGHT_DEPTH,
	parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [15:0] rx_sequence,
	input  logic        ack_present,
	input  logic [15:0] ack_start,
	input  logic [7:0]  ack_length,
	input  logic [31:0] now_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [2:0]  event_res,
	output logic [15:0] sequence_out,
	output logic        accept,
	output logic [15:0] range_start,
	output logic [7:0]  range_length,
	output logic        overflow,
	output logic        last
);

	`include "packet_ack_range_tracker_top_assert.svh"

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.send_acks_enable    <= 1'b0;
			cfg_q.process_acks_enable <= 1'b0;
			cfg_q.timeout_limit       <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEND_ACKS:    cfg_q.send_acks_enable    <= cfg_data[0];
				REG_PROCESS_ACKS: cfg_q.process_acks_enable <= cfg_data[0];
				REG_TIMEOUT:      cfg_q.timeout_limit       <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	part_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.rx_sequence (rx_sequence),
		.ack_present (ack_present),
		.ack_start   (ack_start),
		.ack_length  (ack_length),
		.now_time    (now_time),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	part_back #(
		.FLIGHT_DEPTH  (FLIGHT_DEPTH),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.event_res    (event_res),
		.sequence_out (sequence_out),
		.accept       (accept),
		.range_start  (range_start),
		.range_length (range_length),
		.overflow     (overflow),
		.last         (last)
	);

	`PART_ASSERT_NOW(a_accept_rx, result_valid && accept, event_res == EV_RX, "accept outside rx")
	`PART_ASSERT_NOW(a_ovf_kind, result_valid && overflow,
		event_res == EV_ASSIGNED || event_res == EV_RX, "overflow on wrong event")
	`PART_ASSERT_NEXT(a_mid_walk, result_valid && !last, !cmd_pop,
		"walk broke off after a non-final result")

endmodule

@@ rtl/part_ram.sv @@
module part_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/part_front.sv @@
module part_front
	import part_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [15:0] rx_sequence,
	input  logic        ack_present,
	input  logic [15:0] ack_start,
	input  logic [7:0]  ack_length,
	input  logic [31:0] now_time,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       incoming;

	assign busy      = (count_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	// Classify the item so that the back end only sees a plain operation.
	always_comb begin
		incoming.rx_sequence = rx_sequence;
		incoming.ack_start   = ack_start;
		incoming.ack_length  = ack_length;
		incoming.now_time    = now_time;
		case (mode)
			MODE_SEND:  incoming.op = OP_SEND;
			MODE_RECV:  incoming.op = OP_RECV;
			MODE_ACK:   incoming.op = ack_present ? OP_ACK : OP_NONE;
			MODE_SWEEP: incoming.op = OP_SWEEP;
			MODE_TAKE:  incoming.op = OP_TAKE;
			default:    incoming.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/part_back.sv @@
module part_back
	import part_pkg::*;
#(
	parameter int FLIGHT_DEPTH  = DEF_FLIGHT_DEPTH,
	parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        result_valid,
	output logic [2:0]  event_res,
	output logic [15:0] sequence_out,
	output logic        accept,
	output logic [15:0] range_start,
	output logic [7:0]  range_length,
	output logic        overflow,
	output logic        last
);

	localparam int FA_W = $clog2(FLIGHT_DEPTH);
	localparam int FC_W = $clog2(FLIGHT_DEPTH + 1);
	localparam int PA_W = $clog2(PENDING_DEPTH);
	localparam int PC_W = $clog2(PENDING_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_TAKE
	} state_t;

	state_t      state_q;
	logic        is_sweep_q;
	logic [16:0] nxt_q;
	logic [16:0] end_q;
	logic [31:0] now_q;
	logic [N_W-1:0] n_q;
	logic        held_valid_q;
	logic [2:0]  held_ev_q;
	logic [15:0] held_seq_q;

	logic [15:0] next_out_q;
	logic [15:0] next_exp_q;

	logic [FA_W-1:0] fl_head_q;
	logic [FA_W-1:0] fl_tail_q;
	logic [FC_W-1:0] fl_count_q;
	logic [PA_W-1:0] pd_head_q;
	logic [PA_W-1:0] pd_tail_q;
	logic [PA_W-1:0] pd_last_q;
	logic [PC_W-1:0] pd_count_q;
	logic [15:0]     last_start_q;
	logic [7:0]      last_len_q;

	logic        fl_we;
	logic [47:0] fl_rd;
	logic        pd_we;
	logic [PA_W-1:0] pd_wa;
	logic [23:0] pd_wd;
	logic [23:0] pd_rd;

	logic        fl_full;
	logic        pd_full;
	logic        can_extend;
	logic        rx_ok;
	logic [15:0] fs;
	logic [32:0] age_sum;
	logic        walk_go;
	logic        sweep_fail;

	function automatic logic [FA_W-1:0] fl_inc(input logic [FA_W-1:0] p);
		return (p == FA_W'(FLIGHT_DEPTH - 1)) ? '0 : p + FA_W'(1);
	endfunction

	function automatic logic [PA_W-1:0] pd_inc(input logic [PA_W-1:0] p);
		return (p == PA_W'(PENDING_DEPTH - 1)) ? '0 : p + PA_W'(1);
	endfunction

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign fl_full = (fl_count_q == FC_W'(FLIGHT_DEPTH));
	assign pd_full = (pd_count_q == PC_W'(PENDING_DEPTH));
	assign rx_ok   = (cmd.rx_sequence >= next_exp_q);
	assign can_extend = (pd_count_q != '0) && (last_len_q != 8'hFF)
		&& (({1'b0, last_start_q} + {9'd0, last_len_q}) == {1'b0, cmd.rx_sequence});
	assign fl_we = cmd_pop && (cmd.op == OP_SEND) && cfg.process_acks_enable && !fl_full;

	always_comb begin
		pd_we = 1'b0;
		pd_wa = pd_tail_q;
		pd_wd = {cmd.rx_sequence, 8'd1};
		if (cmd_pop && (cmd.op == OP_RECV) && rx_ok && cfg.send_acks_enable) begin
			if (can_extend) begin
				pd_we = 1'b1;
				pd_wa = pd_last_q;
				pd_wd = {last_start_q, last_len_q + 8'd1};
			end else if (!pd_full) begin
				pd_we = 1'b1;
			end
		end
	end

	part_ram #(.WIDTH(48), .DEPTH(FLIGHT_DEPTH)) u_flight_ram (
		.clk     (clk),
		.we      (fl_we),
		.wr_addr (fl_tail_q),
		.wr_data ({next_out_q, cmd.now_time}),
		.rd_addr (fl_head_q),
		.rd_data (fl_rd)
	);

	part_ram #(.WIDTH(24), .DEPTH(PENDING_DEPTH)) u_pending_ram (
		.clk     (clk),
		.we      (pd_we),
		.wr_addr (pd_wa),
		.wr_data (pd_wd),
		.rd_addr (pd_head_q),
		.rd_data (pd_rd)
	);

	assign fs         = fl_rd[47:32];
	assign age_sum    = {1'b0, fl_rd[31:0]} + {17'd0, cfg.timeout_limit};
	assign walk_go    = (fl_count_q != '0) && (n_q != N_W'(MAX_RESULTS));
	assign sweep_fail = age_sum < {1'b0, now_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			is_sweep_q   <= 1'b0;
			nxt_q        <= '0;
			end_q        <= '0;
			now_q        <= '0;
			n_q          <= '0;
			held_valid_q <= 1'b0;
			held_ev_q    <= EV_NOTHING;
			held_seq_q   <= '0;
			next_out_q   <= '0;
			next_exp_q   <= '0;
			fl_head_q    <= '0;
			fl_tail_q    <= '0;
			fl_count_q   <= '0;
			pd_head_q    <= '0;
			pd_tail_q    <= '0;
			pd_last_q    <= '0;
			pd_count_q   <= '0;
			last_start_q <= '0;
			last_len_q   <= '0;
			result_valid <= 1'b0;
			event_res    <= EV_NOTHING;
			sequence_out <= '0;
			accept       <= 1'b0;
			range_start  <= '0;
			range_length <= '0;
			overflow     <= 1'b0;
			last         <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			event_res    <= EV_NOTHING;
			sequence_out <= '0;
			accept       <= 1'b0;
			range_start  <= '0;
			range_length <= '0;
			overflow     <= 1'b0;
			last         <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						n_q          <= '0;
						held_valid_q <= 1'b0;
						nxt_q        <= {1'b0, cmd.ack_start};
						end_q        <= {1'b0, cmd.ack_start} + {9'd0, cmd.ack_length};
						now_q        <= cmd.now_time;
						case (cmd.op)
							OP_SEND: begin
								result_valid <= 1'b1;
								event_res    <= EV_ASSIGNED;
								sequence_out <= next_out_q;
								overflow     <= cfg.process_acks_enable && fl_full;
								next_out_q   <= next_out_q + 16'd1;
								if (fl_we) begin
									fl_tail_q  <= fl_inc(fl_tail_q);
									fl_count_q <= fl_count_q + FC_W'(1);
								end
							end
							OP_RECV: begin
								result_valid <= 1'b1;
								event_res    <= EV_RX;
								sequence_out <= cmd.rx_sequence;
								accept       <= rx_ok;
								if (rx_ok) begin
									next_exp_q <= cmd.rx_sequence + 16'd1;
									if (cfg.send_acks_enable) begin
										overflow <= !can_extend && pd_full;
										if (can_extend) begin
											last_len_q <= last_len_q + 8'd1;
										end else if (!pd_full) begin
											last_start_q <= cmd.rx_sequence;
											last_len_q   <= 8'd1;
											pd_last_q    <= pd_tail_q;
											pd_tail_q    <= pd_inc(pd_tail_q);
											pd_count_q   <= pd_count_q + PC_W'(1);
										end
									end
								end
							end
							OP_ACK: begin
								is_sweep_q <= 1'b0;
								state_q    <= ST_EVAL;
							end
							OP_SWEEP: begin
								is_sweep_q <= 1'b1;
								state_q    <= ST_EVAL;
							end
							OP_TAKE: begin
								if (pd_count_q != '0) begin
									state_q <= ST_TAKE;
								end else begin
									result_valid <= 1'b1;
								end
							end
							default: begin
								result_valid <= 1'b1;
							end
						endcase
					end
				end
				ST_TAKE: begin
					result_valid <= 1'b1;
					event_res    <= EV_RANGE;
					range_start  <= pd_rd[23:8];
					range_length <= pd_rd[7:0];
					pd_head_q    <= pd_inc(pd_head_q);
					pd_count_q   <= pd_count_q - PC_W'(1);
					state_q      <= ST_IDLE;
				end
				ST_FETCH: begin
					// The head moved at the last edge; its entry is read now.
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (walk_go && (is_sweep_q ? sweep_fail : (nxt_q < end_q))) begin
						if (is_sweep_q || ({1'b0, fs} <= nxt_q)) begin
							// Retire the head; the previous result goes out, not final.
							if (held_valid_q) begin
								result_valid <= 1'b1;
								event_res    <= held_ev_q;
								sequence_out <= held_seq_q;
								last         <= 1'b0;
							end
							held_valid_q <= 1'b1;
							held_seq_q   <= fs;
							held_ev_q    <= (!is_sweep_q && ({1'b0, fs} == nxt_q))
								? EV_DELIVERED : EV_FAILED;
							if (!is_sweep_q && ({1'b0, fs} == nxt_q)) begin
								nxt_q <= nxt_q + 17'd1;
							end
							n_q        <= n_q + N_W'(1);
							fl_head_q  <= fl_inc(fl_head_q);
							fl_count_q <= fl_count_q - FC_W'(1);
							state_q    <= ST_FETCH;
						end else begin
							nxt_q <= nxt_q + 17'd1;
						end
					end else begin
						result_valid <= 1'b1;
						if (held_valid_q) begin
							event_res    <= held_ev_q;
							sequence_out <= held_seq_q;
						end
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
